### design/multi_channel_interval_alarm_timer_defines.svh
// Assertion macros for the interval alarm timer RTL.
// Depends on nothing; files that assert take it by include.
`ifndef MULTI_CHANNEL_INTERVAL_ALARM_TIMER_DEFINES_SVH
`define MULTI_CHANNEL_INTERVAL_ALARM_TIMER_DEFINES_SVH

// Clocked check, masked while reset is held.
`define MCIAT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define MCIAT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/mciat_pkg.sv
// Package for the interval alarm timer: widths, button and stage codes,
// transfer structs and channel reset values. Depends on nothing.
package mciat_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int PERIOD_W         = 18;
    localparam int ENTRY_W          = 6;
    localparam int MASK_W           = 4;
    localparam int BUTTON_W         = 4;
    localparam int CHAN_SEL_W       = 2;
    localparam int ENTRY_MAX        = 59;
    localparam int MIN_WEIGHT       = 60;
    localparam int HOUR_WEIGHT      = 3600;

    typedef enum logic [BUTTON_W-1:0] {
        BTN_NONE    = 4'd0,
        BTN_UP      = 4'd1,
        BTN_DOWN    = 4'd2,
        BTN_CONFIRM = 4'd3,
        BTN_CANCEL  = 4'd4,
        BTN_SEL0    = 4'd5,
        BTN_SEL1    = 4'd6,
        BTN_SEL2    = 4'd7,
        BTN_SEL3    = 4'd8
    } t_button;

    typedef enum logic [1:0] {
        STG_SEC  = 2'd0,
        STG_MIN  = 2'd1,
        STG_HOUR = 2'd2
    } t_stage;

    typedef struct packed {
        logic                cmd;
        logic [BUTTON_W-1:0] button;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0]     alert_mask;
        logic                  editing;
        logic [1:0]            edit_stage;
        logic [ENTRY_W-1:0]    entry_shown;
        logic [CHAN_SEL_W-1:0] selected_channel;
        logic                  display_refresh;
    } t_out_item;

    // Period / enable update from the editor to one channel.
    typedef struct packed {
        logic                period_we;
        logic [PERIOD_W-1:0] period;
        logic                enable_we;
        logic                enable;
    } t_chan_wr;

    function automatic logic [PERIOD_W-1:0] init_period(input int idx);
        logic [PERIOD_W-1:0] v;
        case (idx)
            0:       v = PERIOD_W'(5);
            1:       v = PERIOD_W'(35);
            2:       v = PERIOD_W'(10);
            3:       v = PERIOD_W'(123);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic init_enable(input int idx);
        return (idx == 0) || (idx == 2);
    endfunction

endpackage

### design/multi_channel_interval_alarm_timer.sv
// A transfer passes through the input register, then the result register.
// Throughput: one item per cycle unless the output stalls; the input register
// refills while the result is taken, all channels update in the same cycle.
// Reset (synchronous, active low) restores channel periods/enables, clears
// counts and the editor; no clearing pass, items are taken at once.
module multi_channel_interval_alarm_timer #(
    parameter int NUM_CHANNELS = mciat_pkg::NUM_CHANNELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mciat_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mciat_pkg::t_out_item o_out_item
);
    import mciat_pkg::*;
    `include "multi_channel_interval_alarm_timer_defines.svh"

    // Handshake and pipeline registers
    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    logic      out_free;
    logic      proc;

    // Editor state
    logic                  r_edit;
    t_stage                r_stage;
    logic [ENTRY_W-1:0]    r_entry;
    logic [CHAN_SEL_W-1:0] r_chosen;
    logic                  r_held;
    logic                  n_edit;
    t_stage                n_stage;
    logic [ENTRY_W-1:0]    n_entry;
    logic [CHAN_SEL_W-1:0] n_chosen;
    logic                  n_held;
    logic                  n_refresh;

    logic                tick;
    logic                press;
    logic [BUTTON_W-1:0] sel_idx;
    logic                sel_ok;
    logic [PERIOD_W-1:0] sel_period;
    logic [PERIOD_W-1:0] new_period;
    logic                wr_period;
    logic                wr_enable;
    logic [MASK_W-1:0]   alert_mask;

    logic [PERIOD_W-1:0] ch_period  [NUM_CHANNELS];
    logic                ch_expired [NUM_CHANNELS];
    t_chan_wr            ch_wr      [NUM_CHANNELS];

    assign out_free    = !r_out_vld || !i_out_stall;
    assign proc        = r_in_vld && out_free;
    assign o_in_stall  = r_in_vld && !out_free;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    assign tick    = proc && !r_in.cmd;
    assign press   = proc && r_in.cmd && (r_in.button != BTN_NONE) && !r_held;
    assign sel_idx = r_in.button - BTN_SEL0;
    assign sel_ok  = 32'(sel_idx) < NUM_CHANNELS;

    // Period of the channel under edit
    always_comb begin
        sel_period = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (32'(r_chosen) == c) begin
                sel_period = ch_period[c];
            end
        end
    end

    // Editor next state
    always_comb begin
        n_edit     = r_edit;
        n_stage    = r_stage;
        n_entry    = r_entry;
        n_chosen   = r_chosen;
        n_held     = r_held;
        new_period = sel_period;
        wr_period  = 1'b0;
        wr_enable  = 1'b0;
        if (proc && r_in.cmd) begin
            if (r_in.button == BTN_NONE) begin
                n_held = 1'b0;
            end else if (!r_held) begin
                n_held = 1'b1;
                case (t_button'(r_in.button))
                    BTN_UP: begin
                        if (r_edit) begin
                            n_entry = (32'(r_entry) == ENTRY_MAX) ? '0 : r_entry + ENTRY_W'(1);
                        end
                    end
                    BTN_DOWN: begin
                        if (r_edit) begin
                            n_entry = (r_entry == '0) ? ENTRY_W'(ENTRY_MAX)
                                                      : r_entry - ENTRY_W'(1);
                        end
                    end
                    BTN_CONFIRM: begin
                        if (r_edit) begin
                            case (r_stage)
                                STG_SEC: begin
                                    new_period = PERIOD_W'(r_entry);
                                    wr_period  = 1'b1;
                                    n_entry    = '0;
                                    n_stage    = STG_MIN;
                                end
                                STG_MIN: begin
                                    new_period = sel_period
                                               + PERIOD_W'(r_entry) * PERIOD_W'(MIN_WEIGHT);
                                    wr_period  = 1'b1;
                                    n_entry    = '0;
                                    n_stage    = STG_HOUR;
                                end
                                STG_HOUR: begin
                                    new_period = sel_period
                                               + PERIOD_W'(r_entry) * PERIOD_W'(HOUR_WEIGHT);
                                    wr_period  = 1'b1;
                                    wr_enable  = 1'b1;
                                    n_entry    = '0;
                                    n_stage    = STG_SEC;
                                    n_edit     = 1'b0;
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                    BTN_CANCEL: begin
                        n_edit  = 1'b0;
                        n_entry = '0;
                        n_stage = STG_SEC;
                    end
                    BTN_SEL0, BTN_SEL1, BTN_SEL2, BTN_SEL3: begin
                        if (sel_ok) begin
                            n_edit   = 1'b1;
                            n_chosen = sel_idx[CHAN_SEL_W-1:0];
                            n_entry  = '0;
                            n_stage  = STG_SEC;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Channel update requests
    always_comb begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            ch_wr[c].period_we = wr_period && (32'(r_chosen) == c);
            ch_wr[c].period    = new_period;
            ch_wr[c].enable_we = wr_enable && (32'(r_chosen) == c);
            ch_wr[c].enable    = (new_period != '0);
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_CHANNELS; g++) begin : g_chan
            mciat_channel #(
                .CH_INDEX (g)
            ) u_chan (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_tick    (tick),
                .i_wr      (ch_wr[g]),
                .o_period  (ch_period[g]),
                .o_expired (ch_expired[g])
            );
        end
        for (g = 0; g < MASK_W; g++) begin : g_mask
            if (g < NUM_CHANNELS) begin : g_on
                assign alert_mask[g] = ch_expired[g];
            end else begin : g_off
                assign alert_mask[g] = 1'b0;
            end
        end
    endgenerate

    assign n_refresh = press || (alert_mask != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_edit    <= 1'b0;
            r_stage   <= STG_SEC;
            r_entry   <= '0;
            r_chosen  <= '0;
            r_held    <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
            r_edit   <= n_edit;
            r_stage  <= n_stage;
            r_entry  <= n_entry;
            r_chosen <= n_chosen;
            r_held   <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_item;
        end
        if (proc) begin
            r_out.alert_mask       <= alert_mask;
            r_out.editing          <= n_edit;
            r_out.edit_stage       <= n_stage;
            r_out.entry_shown      <= n_entry;
            r_out.selected_channel <= n_chosen;
            r_out.display_refresh  <= n_refresh;
        end
    end

    `MCIAT_ASSERT(a_proc_fills_out, proc |=> r_out_vld, "processed transfer left no result")
    `MCIAT_ASSERT(a_tick_refresh,
        (proc && !r_in.cmd) |=> (r_out.display_refresh == (r_out.alert_mask != '0)),
        "tick refresh disagrees with alert mask")
    `MCIAT_ASSERT(a_idle_entry_clear, !r_edit |-> (r_stage == STG_SEC && r_entry == '0),
        "entry not cleared outside editing")
    `MCIAT_ASSERT(a_held_no_effect,
        (proc && r_in.cmd && r_in.button != BTN_NONE && r_held)
            |=> ($stable(r_edit) && $stable(r_entry) && $stable(r_chosen)),
        "held button changed editor state")

endmodule

### design/mciat_channel.sv
// One repeating alarm channel: enable, period and running count.
// Depends on mciat_pkg.
module mciat_channel #(
    parameter int CH_INDEX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tick,
    input  mciat_pkg::t_chan_wr           i_wr,
    output logic [mciat_pkg::PERIOD_W-1:0] o_period,
    output logic                          o_expired
);
    import mciat_pkg::*;

    logic                r_enable;
    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] r_count;
    logic                n_enable;
    logic [PERIOD_W-1:0] n_period;
    logic [PERIOD_W-1:0] n_count;

    assign o_expired = i_tick && r_enable && (r_count >= r_period);
    assign o_period  = r_period;

    always_comb begin
        n_enable = i_wr.enable_we ? i_wr.enable : r_enable;
        n_period = i_wr.period_we ? i_wr.period : r_period;
        n_count  = r_count;
        if (i_tick && r_enable) begin
            n_count = o_expired ? '0 : r_count + PERIOD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= init_enable(CH_INDEX);
            r_period <= init_period(CH_INDEX);
            r_count  <= '0;
        end else begin
            r_enable <= n_enable;
            r_period <= n_period;
            r_count  <= n_count;
        end
    end

endmodule

### test/tb.sv
// Self-checking bench for multi_channel_interval_alarm_timer: directed table, then random
// tick and button traffic checked against a behavioural model of the four channel alarm.
// Depends on mciat_pkg and the timer RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mciat_pkg::*;

    localparam int NCH      = NUM_CHANNELS_DEF;
    localparam int DIR_ROWS = 29;
    localparam int RAND_ITEMS = 1400;

    typedef struct packed {
        logic                cmd;
        logic [BUTTON_W-1:0] button;
        logic                typed;
        t_out_item           want;
    } t_plan_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    multi_channel_interval_alarm_timer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // Model state of the timer
    logic [PERIOD_W-1:0] period_m [NCH];
    logic [PERIOD_W-1:0] count_m  [NCH];
    logic                enable_m [NCH];
    logic                edit_m;
    t_stage              stage_m;
    logic [ENTRY_W-1:0]  entry_m;
    logic [CHAN_SEL_W-1:0] chan_m;
    logic                held_m;

    t_plan_row item_plan_q[$];
    t_out_item status_due_q[$];
    int        n_acc;
    int        n_taken;
    int        n_mism;
    int        n_gen;
    logic      gen_held;
    logic      hold_off;
    logic      calm_tx;
    logic      calm_rx;

    // Directed rows: typed expectations only where they follow at a glance
    t_plan_row directed_tab [DIR_ROWS] = '{
        '{1'b0, BTN_NONE,    1'b1, '{4'h0, 1'b0, STG_SEC, 6'd0,  2'd0, 1'b0}},
        '{1'b1, BTN_UP,      1'b1, '{4'h0, 1'b0, STG_SEC, 6'd0,  2'd0, 1'b1}},
        '{1'b1, BTN_DOWN,    1'b1, '{4'h0, 1'b0, STG_SEC, 6'd0,  2'd0, 1'b0}},
        '{1'b1, BTN_NONE,    1'b0, '0},
        '{1'b1, BTN_CONFIRM, 1'b1, '{4'h0, 1'b0, STG_SEC, 6'd0,  2'd0, 1'b1}},
        '{1'b1, BTN_NONE,    1'b0, '0},
        '{1'b1, 4'd15,       1'b1, '{4'h0, 1'b0, STG_SEC, 6'd0,  2'd0, 1'b1}},
        '{1'b1, BTN_NONE,    1'b0, '0},
        '{1'b1, BTN_SEL0,    1'b1, '{4'h0, 1'b1, STG_SEC, 6'd0,  2'd0, 1'b1}},
        '{1'b1, BTN_NONE,    1'b0, '0},
        '{1'b1, BTN_DOWN,    1'b1, '{4'h0, 1'b1, STG_SEC, 6'd59, 2'd0, 1'b1}},
        '{1'b1, BTN_NONE,    1'b0, '0},
        '{1'b1, BTN_UP,      1'b1, '{4'h0, 1'b1, STG_SEC, 6'd0,  2'd0, 1'b1}},
        '{1'b1, BTN_NONE,    1'b0, '0},
        '{1'b1, BTN_UP,      1'b0, '0},
        '{1'b1, BTN_NONE,    1'b0, '0},
        '{1'b1, BTN_CONFIRM, 1'b0, '0},
        '{1'b0, 4'd9,        1'b0, '0},
        '{1'b1, BTN_NONE,    1'b0, '0},
        '{1'b1, BTN_CONFIRM, 1'b0, '0},
        '{1'b1, BTN_NONE,    1'b0, '0},
        '{1'b1, BTN_DOWN,    1'b0, '0},
        '{1'b1, BTN_NONE,    1'b0, '0},
        '{1'b1, BTN_CONFIRM, 1'b0, '0},
        '{1'b1, BTN_NONE,    1'b0, '0},
        '{1'b1, BTN_SEL2,    1'b0, '0},
        '{1'b1, BTN_NONE,    1'b0, '0},
        '{1'b1, BTN_CANCEL,  1'b1, '{4'h0, 1'b0, STG_SEC, 6'd0,  2'd2, 1'b1}},
        '{1'b1, BTN_NONE,    1'b0, '0}
    };

    task automatic reset_alarm_model();
        for (int c = 0; c < NCH; c++) begin
            period_m[c] = (c == 0) ? PERIOD_W'(5) : (c == 1) ? PERIOD_W'(35) :
                          (c == 2) ? PERIOD_W'(10) : PERIOD_W'(123);
            enable_m[c] = (c == 0) || (c == 2);
            count_m[c]  = '0;
        end
        edit_m  = 1'b0;
        stage_m = STG_SEC;
        entry_m = '0;
        chan_m  = '0;
        held_m  = 1'b0;
    endtask

    task automatic apply_press(input logic [BUTTON_W-1:0] code);
        case (code)
            BTN_UP: begin
                if (edit_m) entry_m = (entry_m == ENTRY_MAX) ? '0 : entry_m + 1'b1;
            end
            BTN_DOWN: begin
                if (edit_m) entry_m = (entry_m == '0) ? ENTRY_W'(ENTRY_MAX) : entry_m - 1'b1;
            end
            BTN_CONFIRM: begin
                if (edit_m) begin
                    case (stage_m)
                        STG_SEC: begin
                            period_m[chan_m] = PERIOD_W'(entry_m);
                            stage_m = STG_MIN;
                        end
                        STG_MIN: begin
                            period_m[chan_m] = PERIOD_W'(period_m[chan_m] + entry_m * MIN_WEIGHT);
                            stage_m = STG_HOUR;
                        end
                        default: begin
                            period_m[chan_m] = PERIOD_W'(period_m[chan_m] + entry_m * HOUR_WEIGHT);
                            stage_m = STG_SEC;
                            edit_m  = 1'b0;
                            enable_m[chan_m] = (period_m[chan_m] != '0);
                        end
                    endcase
                    entry_m = '0;
                end
            end
            BTN_CANCEL: begin
                edit_m  = 1'b0;
                entry_m = '0;
                stage_m = STG_SEC;
            end
            BTN_SEL0, BTN_SEL1, BTN_SEL2, BTN_SEL3: begin
                edit_m  = 1'b1;
                chan_m  = CHAN_SEL_W'(code - BTN_SEL0);
                entry_m = '0;
                stage_m = STG_SEC;
            end
            default: ;
        endcase
    endtask

    task automatic advance_alarm(input t_in_item it, output t_out_item res);
        logic [MASK_W-1:0] mask;
        logic              refresh;
        mask    = '0;
        refresh = 1'b0;
        if (!it.cmd) begin
            for (int c = 0; c < NCH; c++) begin
                if (enable_m[c]) begin
                    if (count_m[c] >= period_m[c]) begin
                        count_m[c] = '0;
                        mask[c] = 1'b1;
                    end else begin
                        count_m[c] = count_m[c] + 1'b1;
                    end
                end
            end
            refresh = (mask != '0);
        end else if (it.button == BTN_NONE) begin
            held_m = 1'b0;
        end else if (!held_m) begin
            held_m = 1'b1;
            apply_press(it.button);
            refresh = 1'b1;
        end
        res.alert_mask       = mask;
        res.editing          = edit_m;
        res.edit_stage       = stage_m;
        res.entry_shown      = entry_m;
        res.selected_channel = chan_m;
        res.display_refresh  = refresh;
    endtask

    // Queue one planned transfer; presses swallowed by a held button do not count
    task automatic add_item(input logic cmd, input logic [BUTTON_W-1:0] btn);
        t_plan_row row;
        row = '0;
        row.cmd = cmd;
        row.button = btn;
        item_plan_q.push_back(row);
        if (!cmd || btn == BTN_NONE || !gen_held) n_gen++;
        if (cmd) gen_held = (btn != BTN_NONE);
    endtask

    task automatic press(input logic [BUTTON_W-1:0] btn);
        add_item(1'b1, btn);
        if ($urandom_range(0, 3) == 0) add_item(1'b0, 4'($urandom_range(0, 15)));
        // leave the odd press unreleased so the next one is swallowed
        if ($urandom_range(0, 9) != 0) add_item(1'b1, BTN_NONE);
    endtask

    task automatic plan_edit();
        logic [BUTTON_W-1:0] dir;
        int                  steps;
        bit                  aborted;
        aborted = 1'b0;
        press(BTN_SEL0 + 4'($urandom_range(0, NCH - 1)));
        for (int s = 0; s < 3 && !aborted; s++) begin
            dir = BTN_UP;
            if (s == 0) begin
                steps = $urandom_range(0, 8);
                if ($urandom_range(0, 5) == 0) dir = BTN_DOWN;
            end else if (s == 1) begin
                steps = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
            end else begin
                steps = ($urandom_range(0, 19) == 0) ? 1 : 0;
            end
            repeat (steps) press(dir);
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 6)) add_item(1'b0, 4'($urandom_range(0, 15)));
            if ($urandom_range(0, 19) == 0) begin
                press(BTN_CANCEL);
                aborted = 1'b1;
            end else begin
                press(BTN_CONFIRM);
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("multi_channel_interval_alarm_timer regression: fail");
        $finish;
    end

    // Result check first, then prediction for the transfer taken at the same edge
    always @(posedge i_clk) begin : scoreboard
        t_plan_row row;
        t_out_item predicted;
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_taken++;
            if (status_due_q.size() == 0) begin
                n_mism++;
                if (n_mism <= 10)
                    $display("unexpected result: mask=%h ed=%b stg=%0d ent=%0d sel=%0d rf=%b",
                             o_out_item.alert_mask, o_out_item.editing, o_out_item.edit_stage,
                             o_out_item.entry_shown, o_out_item.selected_channel,
                             o_out_item.display_refresh);
            end else begin
                want = status_due_q.pop_front();
                if (o_out_item.alert_mask       !== want.alert_mask  ||
                    o_out_item.editing          !== want.editing     ||
                    o_out_item.edit_stage       !== want.edit_stage  ||
                    o_out_item.entry_shown      !== want.entry_shown ||
                    o_out_item.selected_channel !== want.selected_channel ||
                    o_out_item.display_refresh  !== want.display_refresh) begin
                    n_mism++;
                    if (n_mism <= 10)
                        $display("mismatch on result %0d: expected mask=%h ed=%b stg=%0d ",
                                 n_taken, want.alert_mask, want.editing, want.edit_stage,
                                 "ent=%0d sel=%0d rf=%b, ",
                                 want.entry_shown, want.selected_channel,
                                 want.display_refresh,
                                 "got mask=%h ed=%b stg=%0d ent=%0d sel=%0d rf=%b",
                                 o_out_item.alert_mask, o_out_item.editing,
                                 o_out_item.edit_stage, o_out_item.entry_shown,
                                 o_out_item.selected_channel, o_out_item.display_refresh);
                end
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            row = item_plan_q[n_acc];
            n_acc++;
            advance_alarm(t_in_item'({row.cmd, row.button}), predicted);
            status_due_q.push_back(row.typed ? row.want : predicted);
        end
    end

    // Receiver: random stall per result, plus the long hold-off when asked
    initial begin : receiver
        int w;
        i_out_stall = 1'b0;
        calm_rx = 1'b0;
        forever begin
            if ($urandom_range(0, 39) == 0) calm_rx = !calm_rx;
            w = calm_rx ? 0 : $urandom_range(0, 18);
            if (w > 0 || hold_off) begin
                i_out_stall <= 1'b1;
                repeat (w) @(negedge i_clk);
                while (hold_off) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Hold the output off long enough for the block to back up to its input
    initial begin : back_pressure
        hold_off = 1'b0;
        wait (n_taken >= 300);
        @(negedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : sender
        int gap;
        int r;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        n_acc   = 0;
        n_taken = 0;
        n_mism  = 0;
        gen_held = 1'b0;
        calm_tx  = 1'b0;
        reset_alarm_model();

        for (int i = 0; i < DIR_ROWS; i++) item_plan_q.push_back(directed_tab[i]);
        gen_held = 1'b0;
        n_gen = 0;
        while (n_gen < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                repeat ($urandom_range(1, 16)) add_item(1'b0, 4'($urandom_range(0, 15)));
            end else if (r < 80) begin
                plan_edit();
            end else begin
                repeat ($urandom_range(1, 6))
                    add_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < item_plan_q.size(); i++) begin
            if ($urandom_range(0, 39) == 0) calm_tx = !calm_tx;
            gap = calm_tx ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_item  <= t_in_item'({item_plan_q[i].cmd, item_plan_q[i].button});
            // hold the transfer until the block takes it
            do @(posedge i_clk); while (o_in_stall);
            @(negedge i_clk);
        end
        i_in_valid <= 1'b0;

        while (status_due_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_mism == 0 && status_due_q.size() == 0) begin
            $display("multi_channel_interval_alarm_timer regression: pass");
        end else begin
            $display("multi_channel_interval_alarm_timer regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/mciat_pkg.sv
design/mciat_channel.sv
design/multi_channel_interval_alarm_timer.sv
test/tb.sv
